FILE: rtl/afd_pkg.sv
`timescale 1ns / 1ps

package afd_pkg;

  localparam int MaxPayloadDefault = 128;
  localparam int LenFieldW = 16;

  localparam int PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_HUNT   = 3'd0;
  localparam logic [PhaseW-1:0] PH_LEN_HI = 3'd1;
  localparam logic [PhaseW-1:0] PH_LEN_LO = 3'd2;
  localparam logic [PhaseW-1:0] PH_DATA   = 3'd3;
  localparam logic [PhaseW-1:0] PH_SUM    = 3'd4;

  localparam logic [7:0] DELIM    = 8'h7E;
  localparam logic [7:0] ESC_MARK = 8'h7D;
  localparam logic [7:0] ESC_FLIP = 8'h20;
  localparam logic [7:0] SUM_GOOD = 8'hFF;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [6:0] offset;
    logic [7:0] length;
    logic       ok;
  } result_t;

endpackage

FILE: rtl/afd_step.sv
`timescale 1ns / 1ps

module afd_step #(
  parameter int MAX_PAYLOAD = afd_pkg::MaxPayloadDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic              buf_full,
  output logic              push,
  output afd_pkg::result_t  push_data
);

  localparam int LenW = $clog2(MAX_PAYLOAD + 1);
  localparam int LenFieldSel = afd_pkg::LenFieldW;
  localparam int LenFieldW = afd_pkg::LenFieldW;

  logic                        rx_valid;
  logic [7:0]                  rx_q;
  logic                        advance;
  logic                        accept;

  logic [afd_pkg::PhaseW-1:0]  phase;
  logic [afd_pkg::PhaseW-1:0]  phase_next;
  logic                        esc;
  logic                        esc_next;
  logic [7:0]                  len_high;
  logic [7:0]                  len_high_next;
  logic [LenW-1:0]             payload_length;
  logic [LenW-1:0]             payload_length_next;
  logic [LenW-1:0]             bytes_seen;
  logic [LenW-1:0]             bytes_seen_next;
  logic [7:0]                  running_sum;
  logic [7:0]                  running_sum_next;

  assign in_stall = rx_valid & buf_full;
  assign accept   = in_valid & ~in_stall;
  assign advance  = rx_valid & ~buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_valid <= 1'b0;
    end else if (accept) begin
      rx_valid <= 1'b1;
    end else if (advance) begin
      rx_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rx_q <= rx_byte;
    end
  end

  always_comb begin
    logic [7:0]           b;
    logic                 have_byte;
    logic [LenFieldSel:0] full_len;
    logic [LenW-1:0]      bytes_inc;
    logic [7:0]           sum_add;
    logic [LenFieldW-1:0] len_wide;
    logic [LenFieldW-1:0] off_wide;

    phase_next          = phase;
    esc_next            = esc;
    len_high_next       = len_high;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    running_sum_next    = running_sum;
    push                = 1'b0;
    b                   = rx_q;
    have_byte           = 1'b0;
    full_len            = {1'b0, len_high, rx_q};
    bytes_inc           = bytes_seen + 1'b1;
    sum_add             = running_sum + rx_q;
    len_wide            = LenFieldW'(payload_length);
    off_wide            = LenFieldW'(bytes_seen);

    push_data.kind   = afd_pkg::KIND_DATA;
    push_data.data   = 8'd0;
    push_data.offset = off_wide[6:0];
    push_data.length = len_wide[7:0];
    push_data.ok     = 1'b0;

    if (phase inside {afd_pkg::PH_LEN_HI, afd_pkg::PH_LEN_LO, afd_pkg::PH_DATA,
                      afd_pkg::PH_SUM}) begin
      if (esc) begin
        esc_next  = 1'b0;
        b         = rx_q ^ afd_pkg::ESC_FLIP;
        have_byte = 1'b1;
      end else if (rx_q == afd_pkg::ESC_MARK) begin
        esc_next  = 1'b1;
      end else begin
        have_byte = 1'b1;
      end
      full_len = {1'b0, len_high, b};
      sum_add  = running_sum + b;
      if (have_byte) begin
        case (phase)
          afd_pkg::PH_LEN_HI: begin
            len_high_next = b;
            phase_next    = afd_pkg::PH_LEN_LO;
          end
          afd_pkg::PH_LEN_LO: begin
            if (full_len > (LenFieldW + 1)'(MAX_PAYLOAD)) begin
              full_len = (LenFieldW + 1)'(MAX_PAYLOAD);
            end
            payload_length_next = LenW'(full_len);
            bytes_seen_next     = '0;
            running_sum_next    = 8'd0;
            phase_next = (full_len == '0) ? afd_pkg::PH_SUM : afd_pkg::PH_DATA;
          end
          afd_pkg::PH_DATA: begin
            running_sum_next = sum_add;
            bytes_seen_next  = bytes_inc;
            if (bytes_inc >= payload_length) begin
              phase_next = afd_pkg::PH_SUM;
            end
            push           = advance;
            push_data.kind = afd_pkg::KIND_DATA;
            push_data.data = b;
          end
          default: begin
            running_sum_next = sum_add;
            phase_next       = afd_pkg::PH_HUNT;
            esc_next         = 1'b0;
            push             = advance;
            push_data.kind   = afd_pkg::KIND_END;
            push_data.offset = 7'd0;
            push_data.ok     = (sum_add == afd_pkg::SUM_GOOD);
          end
        endcase
      end
    end else begin
      phase_next = afd_pkg::PH_HUNT;
      esc_next   = 1'b0;
      if (rx_q == afd_pkg::DELIM) begin
        phase_next          = afd_pkg::PH_LEN_HI;
        len_high_next       = 8'd0;
        payload_length_next = '0;
        bytes_seen_next     = '0;
        running_sum_next    = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= afd_pkg::PH_HUNT;
      esc            <= 1'b0;
      len_high       <= 8'd0;
      payload_length <= '0;
      bytes_seen     <= '0;
      running_sum    <= 8'd0;
    end else if (advance) begin
      phase          <= phase_next;
      esc            <= esc_next;
      len_high       <= len_high_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

FILE: rtl/afd_out_buf.sv
`timescale 1ns / 1ps

module afd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  afd_pkg::result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output afd_pkg::result_t  head
);

  afd_pkg::result_t q0;
  afd_pkg::result_t q1;
  logic [1:0]       count;
  logic             pop;

  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop       = out_valid & ~out_stall;
  assign head      = q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (count == 2'd1) begin
        q0 <= push_data;
      end else begin
        q0 <= q1;
        q1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= push_data;
      end else begin
        q1 <= push_data;
      end
    end else if (pop) begin
      q0 <= q1;
    end
  end

endmodule

FILE: rtl/api_frame_escaped_decoder.sv
`timescale 1ns / 1ps

// Escaped API frame receiver. Takes one serial byte per request, hunts for
// the 0x7E delimiter, un-escapes 0x7D sequences, reads a 16-bit length
// clamped to MAX_PAYLOAD, then reports each payload byte with its offset and
// finishes each frame with one end-of-frame request carrying the checksum
// verdict. Sustained rate is one byte per clock: the frame state machine
// finishes each byte in a single pass between the input register and a
// two-entry output buffer, so a request can be taken every cycle while the
// output side keeps up. Each result is held first in the input register, then in the
// output buffer; the input side stalls only when both entries are held.

module api_frame_escaped_decoder #(
  parameter int MAX_PAYLOAD = afd_pkg::MaxPayloadDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       result_kind,
  output logic [7:0] payload_byte,
  output logic [6:0] byte_offset,
  output logic [7:0] frame_length,
  output logic       checksum_ok
);

  logic             buf_full;
  logic             push;
  afd_pkg::result_t push_data;
  afd_pkg::result_t head;

  afd_step #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .buf_full  (buf_full),
    .push      (push),
    .push_data (push_data)
  );

  afd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign result_kind  = head.kind;
  assign payload_byte = head.data;
  assign byte_offset  = head.offset;
  assign frame_length = head.length;
  assign checksum_ok  = head.ok;

endmodule

FILE: rtl/afd_checker.sv
`timescale 1ns / 1ps

module afd_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       result_kind,
  input logic [7:0] payload_byte,
  input logic [6:0] byte_offset,
  input logic [7:0] frame_length,
  input logic       checksum_ok
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a request two cycles earlier");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == afd_pkg::KIND_END) |->
      (payload_byte == 8'd0 && byte_offset == 7'd0))
    else $error("end of frame carries payload fields");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(result_kind) && $stable(payload_byte) &&
       $stable(byte_offset) && $stable(frame_length) && $stable(checksum_ok)))
    else $error("stalled result changed");

endmodule

bind api_frame_escaped_decoder afd_props u_checker (.*);
